>>> rtl/bws_pkg.sv
// shared types, constants and constant tables of the band-limited wave synth
`default_nettype none
package bws_pkg;

  localparam int MAX_HARMONICS    = 64;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SAMPLE_BITS      = 24;

  localparam int TBL_BITS  = $clog2(SINE_TABLE_DEPTH);
  localparam int QTR_BITS  = TBL_BITS - 2;
  localparam int QTR_DEPTH = SINE_TABLE_DEPTH / 4;

  localparam int SINE_MAG_W = 23;
  localparam int SINE_W     = 24;
  localparam int W_W        = 25;
  localparam int B_W        = 32;
  localparam int Y_W        = 28;
  localparam int P_W        = Y_W + B_W;
  localparam int ACC_W      = 52;
  localparam int CNT_W      = $clog2(MAX_HARMONICS + 1);
  localparam int HIDX_W     = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;

  localparam int SH_ACC   = 24;
  localparam int SH_SCALE = 30;
  localparam int SH_AMP   = 40 - SAMPLE_BITS;

  localparam logic signed [ACC_W-1:0] ACC_HALF    = ACC_W'(64'd1 << (SH_ACC - 1));
  localparam logic signed [ACC_W-1:0] ACC_HALF_M1 = ACC_W'((64'd1 << (SH_ACC - 1)) - 64'd1);
  localparam logic signed [P_W-1:0]   SC_HALF     = P_W'(64'd1 << (SH_SCALE - 1));
  localparam logic signed [P_W-1:0]   SC_HALF_M1  = P_W'((64'd1 << (SH_SCALE - 1)) - 64'd1);
  localparam logic signed [P_W-1:0]   AMP_HALF    = P_W'(64'd1 << (SH_AMP - 1));
  localparam logic signed [P_W-1:0]   AMP_HALF_M1 = P_W'((64'd1 << (SH_AMP - 1)) - 64'd1);

  localparam logic signed [P_W-1:0] SAMP_MAX = P_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [P_W-1:0] SAMP_MIN = P_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  localparam logic signed [B_W-1:0] SCALE_ONE   = 32'sd1073741824;
  localparam logic signed [B_W-1:0] SCALE_2_PI  = 32'sd683565276;
  localparam logic signed [B_W-1:0] SCALE_4_PI  = 32'sd1367130551;
  localparam logic signed [B_W-1:0] SCALE_8_PI2 = 32'sd870342336;

  localparam logic [63:0] POLY_A1  = 64'd1686629713;
  localparam logic [63:0] POLY_A3  = 64'd693598669;
  localparam logic [63:0] POLY_A5  = 64'd85569306;
  localparam logic [63:0] POLY_A7  = 64'd5026995;
  localparam logic [63:0] POLY_A9  = 64'd172272;
  localparam logic [63:0] POLY_A11 = 64'd3864;
  localparam logic [63:0] Q22_ONE  = 64'd4194304;

  typedef enum logic [2:0] {
    WAVE_SINE      = 3'd0,
    WAVE_SAW_DOWN  = 3'd1,
    WAVE_SQUARE    = 3'd2,
    WAVE_SAW_UP    = 3'd3,
    WAVE_TRIANGLE  = 3'd4
  } wave_t;

  typedef enum logic [1:0] {
    REG_WAVEFORM       = 2'd0,
    REG_AMPLITUDE      = 2'd1,
    REG_PHASE_STEP     = 2'd2,
    REG_HARMONIC_COUNT = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_RND1,
    ST_MUL1,
    ST_RND2,
    ST_MUL2,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    WK_HARM,
    WK_ODD,
    WK_ODD_SQ
  } wkind_t;

  typedef struct packed {
    logic acc_clr;
    logic term_vld;
    logic term_neg;
    logic mul_en;
    logic mul_use_y;
    logic y_from_acc;
    logic y_from_prod;
  } mac_ctrl_t;

  typedef logic [SINE_MAG_W-1:0] qtr_tab_t [0:QTR_DEPTH-1];
  typedef logic [W_W-1:0]        wtab_t    [0:MAX_HARMONICS-1];

  // quarter-wave sine magnitude in Q22 for a Q30 angle fraction
  function automatic logic [SINE_MAG_W-1:0] sine_mag(logic [63:0] u);
    logic [63:0] u2;
    logic [63:0] p;
    logic [63:0] r;
    u2 = (u * u) >> 30;
    p  = POLY_A11;
    p  = POLY_A9 - ((p * u2) >> 30);
    p  = POLY_A7 - ((p * u2) >> 30);
    p  = POLY_A5 - ((p * u2) >> 30);
    p  = POLY_A3 - ((p * u2) >> 30);
    p  = POLY_A1 - ((p * u2) >> 30);
    r  = (p * u) >> 30;
    r  = (r + 64'd128) >> 8;
    if (r > Q22_ONE) begin
      r = Q22_ONE;
    end
    return r[SINE_MAG_W-1:0];
  endfunction

  function automatic qtr_tab_t build_qtr();
    qtr_tab_t t;
    for (int j = 0; j < QTR_DEPTH; j++) begin
      t[j] = sine_mag(64'(j) << (30 - QTR_BITS));
    end
    return t;
  endfunction

  // rounded 2^24 / d by long division
  function automatic logic [W_W-1:0] recip_q24(logic [31:0] d);
    logic [31:0] num;
    logic [32:0] rem;
    logic [31:0] q;
    num = 32'd16777216 + (d >> 1);
    rem = '0;
    q   = '0;
    for (int i = 31; i >= 0; i--) begin
      rem = {rem[31:0], num[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q[W_W-1:0];
  endfunction

  function automatic wtab_t build_wtab(wkind_t kind);
    wtab_t       t;
    logic [31:0] n;
    logic [31:0] d;
    for (int i = 0; i < MAX_HARMONICS; i++) begin
      n = (kind == WK_HARM) ? 32'(i + 1) : 32'(2 * i + 1);
      d = (kind == WK_ODD_SQ) ? 32'(n * n) : n;
      t[i] = recip_q24(d);
    end
    return t;
  endfunction

  localparam qtr_tab_t SINE_QTR = build_qtr();
  // magnitude at a quarter cycle, the end point of the quarter table
  localparam logic [SINE_MAG_W-1:0] SINE_PEAK = sine_mag(64'd1 << 30);
  localparam wtab_t    W_HARM   = build_wtab(WK_HARM);
  localparam wtab_t    W_ODD    = build_wtab(WK_ODD);
  localparam wtab_t    W_ODD_SQ = build_wtab(WK_ODD_SQ);

endpackage
`default_nettype wire

>>> rtl/bws_sine_rom.sv
// quarter-wave sine table with registered read
`default_nettype none
module bws_sine_rom (
  input  logic                              clk,
  input  logic [31:0]                       phase,
  output logic signed [bws_pkg::SINE_W-1:0] sine
);
  import bws_pkg::*;

  logic [TBL_BITS-1:0]   idx;
  logic [1:0]            quad;
  logic [QTR_BITS-1:0]   j;
  logic [QTR_BITS:0]     jj;
  logic [SINE_MAG_W-1:0] mag;
  logic signed [SINE_W-1:0] sine_nxt;
  logic signed [SINE_W-1:0] sine_r;

  always_comb begin
    idx  = phase[31 -: TBL_BITS];
    quad = idx[TBL_BITS-1 -: 2];
    j    = idx[QTR_BITS-1:0];
    jj   = quad[0] ? ((QTR_BITS+1)'(QTR_DEPTH) - {1'b0, j}) : {1'b0, j};
    mag  = (jj == (QTR_BITS+1)'(QTR_DEPTH)) ? SINE_PEAK : SINE_QTR[jj[QTR_BITS-1:0]];
    sine_nxt = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk) begin
    sine_r <= sine_nxt;
  end

  assign sine = sine_r;

endmodule
`default_nettype wire

>>> rtl/bws_mac.sv
// shared multiplier, harmonic accumulator, rounding and saturation
`default_nettype none
module bws_mac (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  bws_pkg::mac_ctrl_t                     ctrl,
  input  logic signed [bws_pkg::SINE_W-1:0]      sine,
  input  logic signed [bws_pkg::B_W-1:0]         mul_b,
  output logic signed [bws_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                   clipped
);
  import bws_pkg::*;

  logic signed [Y_W-1:0]   mul_a;
  logic signed [P_W-1:0]   prod_nxt;
  logic signed [P_W-1:0]   prod_r;
  logic                    v2_r;
  logic                    neg2_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [ACC_W-1:0] term;
  logic signed [Y_W-1:0]   y_r;
  logic signed [Y_W-1:0]   y_nxt;
  logic signed [ACC_W-1:0] acc_bias;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [P_W-1:0]   sc_bias;
  logic signed [P_W-1:0]   sc_rnd;
  logic signed [P_W-1:0]   amp_bias;
  logic signed [P_W-1:0]   amp_rnd;

  always_comb begin
    mul_a    = ctrl.mul_use_y ? y_r : $signed({{(Y_W-SINE_W){sine[SINE_W-1]}}, sine});
    prod_nxt = mul_a * mul_b;

    term    = $signed(prod_r[ACC_W-1:0]);
    acc_nxt = acc_r;
    if (ctrl.acc_clr) begin
      acc_nxt = '0;
    end else if (v2_r) begin
      acc_nxt = neg2_r ? (acc_r - term) : (acc_r + term);
    end

    // round half away from zero
    acc_bias = acc_r + (acc_r[ACC_W-1] ? ACC_HALF_M1 : ACC_HALF);
    acc_rnd  = acc_bias >>> SH_ACC;
    sc_bias  = prod_r + (prod_r[P_W-1] ? SC_HALF_M1 : SC_HALF);
    sc_rnd   = sc_bias >>> SH_SCALE;
    amp_bias = prod_r + (prod_r[P_W-1] ? AMP_HALF_M1 : AMP_HALF);
    amp_rnd  = amp_bias >>> SH_AMP;

    y_nxt = y_r;
    if (ctrl.y_from_acc) begin
      y_nxt = $signed(acc_rnd[Y_W-1:0]);
    end else if (ctrl.y_from_prod) begin
      y_nxt = $signed(sc_rnd[Y_W-1:0]);
    end

    priority if (amp_rnd > SAMP_MAX) begin
      sample  = $signed(SAMP_MAX[SAMPLE_BITS-1:0]);
      clipped = 1'b1;
    end else if (amp_rnd < SAMP_MIN) begin
      sample  = $signed(SAMP_MIN[SAMPLE_BITS-1:0]);
      clipped = 1'b1;
    end else begin
      sample  = $signed(amp_rnd[SAMPLE_BITS-1:0]);
      clipped = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= ctrl.term_vld;
    end
  end

  always_ff @(posedge clk) begin
    neg2_r <= ctrl.term_neg;
    acc_r  <= acc_nxt;
    y_r    <= y_nxt;
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/bws_seq.sv
// sequencer: phase, harmonic stepping, coefficient lookup and operand select
`default_nettype none
module bws_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_restart,
  input  logic [2:0]                     waveform,
  input  logic [15:0]                    amplitude,
  input  logic [31:0]                    phase_step,
  input  logic [6:0]                     harmonic_count,
  input  logic                           out_free,
  output logic                           in_ready,
  output logic [31:0]                    rom_phase,
  output logic signed [bws_pkg::B_W-1:0] mul_b,
  output bws_pkg::mac_ctrl_t             ctrl,
  output logic                           out_load
);
  import bws_pkg::*;

  state_t           state_r, state_nxt;
  wave_t            mode_r, mode_nxt, mode_in;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_in;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [31:0]      hphase_r, hphase_nxt;
  logic [31:0]      hstep_r, hstep_nxt;
  logic [31:0]      phase_r, phase_nxt;
  logic [31:0]      base;
  logic             drain_r, drain_nxt;
  logic             v1_r, v1_nxt;
  logic             neg1_r, neg1_nxt;
  logic [W_W-1:0]   w_r, w_nxt;
  logic [HIDX_W-1:0] hidx;
  logic signed [B_W-1:0] scale;

  always_comb begin
    unique case (wave_t'(waveform))
      WAVE_SAW_DOWN, WAVE_SQUARE, WAVE_SAW_UP, WAVE_TRIANGLE: mode_in = wave_t'(waveform);
      default: mode_in = WAVE_SINE;
    endcase

    priority if (mode_in == WAVE_SINE || harmonic_count == 7'd0) begin
      cnt_in = CNT_W'(1);
    end else if (32'(harmonic_count) > 32'(MAX_HARMONICS)) begin
      cnt_in = CNT_W'(MAX_HARMONICS);
    end else begin
      cnt_in = CNT_W'(harmonic_count);
    end

    hidx = k_r[HIDX_W-1:0];
    unique case (mode_r)
      WAVE_SQUARE:   w_nxt = W_ODD[hidx];
      WAVE_TRIANGLE: w_nxt = W_ODD_SQ[hidx];
      default:       w_nxt = W_HARM[hidx];
    endcase
    neg1_nxt = (mode_r == WAVE_SAW_UP || mode_r == WAVE_TRIANGLE) && hidx[0];

    unique case (mode_r)
      WAVE_SINE:     scale = SCALE_ONE;
      WAVE_SQUARE:   scale = SCALE_4_PI;
      WAVE_TRIANGLE: scale = SCALE_8_PI2;
      default:       scale = SCALE_2_PI;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    cnt_nxt    = cnt_r;
    k_nxt      = k_r;
    hphase_nxt = hphase_r;
    hstep_nxt  = hstep_r;
    phase_nxt  = phase_r;
    drain_nxt  = drain_r;
    v1_nxt     = (state_r == ST_RUN);
    in_ready   = 1'b0;
    out_load   = 1'b0;
    ctrl       = '0;
    base       = in_restart ? 32'd0 : phase_r;
    mul_b      = $signed({{(B_W-W_W){1'b0}}, w_r});

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mode_nxt     = mode_in;
          cnt_nxt      = cnt_in;
          k_nxt        = '0;
          hphase_nxt   = base;
          hstep_nxt    = (mode_in == WAVE_SQUARE || mode_in == WAVE_TRIANGLE) ?
                         {base[30:0], 1'b0} : base;
          phase_nxt    = base + phase_step;
          ctrl.acc_clr = 1'b1;
          state_nxt    = ST_RUN;
        end
      end
      ST_RUN: begin
        hphase_nxt = hphase_r + hstep_r;
        k_nxt      = k_r + 1'b1;
        if (k_r == CNT_W'(cnt_r - 1'b1)) begin
          drain_nxt = 1'b0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = ST_RND1;
        end
      end
      ST_RND1: begin
        ctrl.y_from_acc = 1'b1;
        state_nxt       = ST_MUL1;
      end
      ST_MUL1: begin
        ctrl.mul_en    = 1'b1;
        ctrl.mul_use_y = 1'b1;
        mul_b          = scale;
        state_nxt      = ST_RND2;
      end
      ST_RND2: begin
        ctrl.y_from_prod = 1'b1;
        state_nxt        = ST_MUL2;
      end
      ST_MUL2: begin
        ctrl.mul_en    = 1'b1;
        ctrl.mul_use_y = 1'b1;
        mul_b          = $signed({{(B_W-16){1'b0}}, amplitude});
        state_nxt      = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    ctrl.term_vld = v1_r;
    ctrl.term_neg = neg1_r;
    if (v1_r) begin
      ctrl.mul_en = 1'b1;
    end
  end

  assign rom_phase = hphase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= '0;
      drain_r <= 1'b0;
      v1_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      drain_r <= drain_nxt;
      v1_r    <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    cnt_r    <= cnt_nxt;
    k_r      <= k_nxt;
    hphase_r <= hphase_nxt;
    hstep_r  <= hstep_nxt;
    neg1_r   <= neg1_nxt;
    w_r      <= w_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/bandlimited_wave_synth.sv
// top level of the band-limited wave synth: registers, output stage, wiring
//
//  channel  ports                                    moves
//  cfg      cfg_valid cfg_ready cfg_index cfg_data   one register write
//  in       in_valid in_ready in_restart             one sample request
//  out      out_valid out_ready out_sample           one sample item
//           out_clipped
//
// an accepted item runs through RUN for N harmonics (N the harmonic count
// after clamping, 1 for sine), DRAIN, RND1, MUL1, RND2 and MUL2, then DONE
// loads the output register and IDLE takes the next item; one multiplier
// handles one harmonic a cycle; the scale and amplitude products reuse it
// reset loads register defaults and clears the phase
// in_ready is low while an item is at work; the last step waits while the
// output register still holds an item that is not taken
`default_nettype none
module bandlimited_wave_synth (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [1:0]                             cfg_index,
  input  logic [31:0]                            cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_restart,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [bws_pkg::SAMPLE_BITS-1:0] out_sample,
  output logic                                   out_clipped
);
  import bws_pkg::*;

  logic [2:0]  waveform_r;
  logic [15:0] amplitude_r;
  logic [31:0] phase_step_r;
  logic [6:0]  harmonic_count_r;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                          out_clipped_r;

  logic                          out_free;
  logic                          out_load;
  logic [31:0]                   rom_phase;
  logic signed [SINE_W-1:0]      sine;
  logic signed [B_W-1:0]         mul_b;
  mac_ctrl_t                     ctrl;
  logic signed [SAMPLE_BITS-1:0] mac_sample;
  logic                          mac_clipped;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waveform_r       <= 3'd0;
      amplitude_r      <= 16'd0;
      phase_step_r     <= 32'd0;
      harmonic_count_r <= 7'd1;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WAVEFORM:       waveform_r       <= cfg_data[2:0];
        REG_AMPLITUDE:      amplitude_r      <= cfg_data[15:0];
        REG_PHASE_STEP:     phase_step_r     <= cfg_data;
        REG_HARMONIC_COUNT: harmonic_count_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || out_ready;

  bws_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_restart     (in_restart),
    .waveform       (waveform_r),
    .amplitude      (amplitude_r),
    .phase_step     (phase_step_r),
    .harmonic_count (harmonic_count_r),
    .out_free       (out_free),
    .in_ready       (in_ready),
    .rom_phase      (rom_phase),
    .mul_b          (mul_b),
    .ctrl           (ctrl),
    .out_load       (out_load)
  );

  bws_sine_rom u_rom (
    .clk   (clk),
    .phase (rom_phase),
    .sine  (sine)
  );

  bws_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .sine    (sine),
    .mul_b   (mul_b),
    .sample  (mac_sample),
    .clipped (mac_clipped)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r  <= mac_sample;
      out_clipped_r <= mac_clipped;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_sample  = out_sample_r;
  assign out_clipped = out_clipped_r;

endmodule
`default_nettype wire

>>> tb/tb_bandlimited_wave_synth.sv
// self-checking testbench of the band-limited wave synth with a sample predictor
module tb_bandlimited_wave_synth;
  import bws_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int RAND_ITEMS = 1900;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int TAIL_CYCLES = 100;
  localparam int HOLD_PERIOD = 40000;
  localparam int HOLD_LEN = 600;

  localparam logic [2:0] WAVE_UNUSED_5 = 3'd5;
  localparam logic [2:0] WAVE_UNUSED_7 = 3'd7;

  localparam longint unsigned K1 = 64'd1686629713;
  localparam longint unsigned K3 = 64'd693598669;
  localparam longint unsigned K5 = 64'd85569306;
  localparam longint unsigned K7 = 64'd5026995;
  localparam longint unsigned K9 = 64'd172272;
  localparam longint unsigned K11 = 64'd3864;
  localparam longint unsigned Q22_UNIT = 64'd4194304;
  localparam longint GAIN_UNITY = 64'sd1073741824;
  localparam longint GAIN_SAW = 64'sd683565276;
  localparam longint GAIN_SQUARE = 64'sd1367130551;
  localparam longint GAIN_TRIANGLE = 64'sd870342336;
  localparam longint SAMPLE_HI = (64'sd1 <<< (SB - 1)) - 64'sd1;
  localparam longint SAMPLE_LO = -(64'sd1 <<< (SB - 1));

  typedef struct packed {
    logic signed [SB-1:0] sample;
    logic clipped;
  } synth_out_t;

  typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t kind;
    cfg_reg_t idx;
    logic [31:0] data;
    logic restart;
    bit typed;
    logic signed [SB-1:0] sample;
  } bringup_row_t;

  typedef enum {RX_OPEN, RX_COIN, RX_EVERY4, RX_SPARSE} rx_pattern_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SB-1:0] out_sample;
  logic out_clipped;

  // predictor state
  int sine_lut [SINE_TABLE_DEPTH];
  logic [2:0] wave_reg = 3'd0;
  logic [15:0] amp_reg = 16'd0;
  logic [31:0] step_reg = 32'd0;
  logic [6:0] hcount_reg = 7'd1;
  logic [31:0] phase_acc = 32'd0;

  synth_out_t pending_samples[$];
  bringup_row_t bringup_rows[$];
  int samples_sent = 0;
  int samples_taken = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;

  int rx_cycle = 0;
  int hold_left = 0;
  int pattern_left = 0;
  rx_pattern_t rx_pat = RX_OPEN;

  bandlimited_wave_synth dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_restart(in_restart),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_sample(out_sample),
    .out_clipped(out_clipped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // quarter-wave odd polynomial, Q30 in, Q22 out
  function automatic longint unsigned poly_mag(input longint unsigned u);
    longint unsigned sq;
    longint unsigned p;
    longint unsigned r;
    sq = (u * u) >> 30;
    p = K11;
    p = K9 - ((p * sq) >> 30);
    p = K7 - ((p * sq) >> 30);
    p = K5 - ((p * sq) >> 30);
    p = K3 - ((p * sq) >> 30);
    p = K1 - ((p * sq) >> 30);
    r = (p * u) >> 30;
    r = (r + 64'd128) >> 8;
    if (r > Q22_UNIT) begin
      r = Q22_UNIT;
    end
    return r;
  endfunction

  function automatic longint round_away(input longint v, input int sh);
    longint unsigned mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic synth_out_t synth_next(input logic restart);
    wave_t mode;
    int unsigned terms;
    int unsigned n;
    int unsigned d;
    longint sum;
    longint y;
    longint gain;
    longint w;
    longint term;
    logic [31:0] hp;
    longint unsigned idx;
    synth_out_t r;
    mode = (wave_reg > 3'd4) ? WAVE_SINE : wave_t'(wave_reg);
    if (restart) begin
      phase_acc = '0;
    end
    terms = 32'(hcount_reg);
    if (terms < 1) begin
      terms = 1;
    end
    if (terms > MAX_HARMONICS) begin
      terms = MAX_HARMONICS;
    end
    if (mode == WAVE_SINE) begin
      terms = 1;
    end
    sum = 0;
    for (int unsigned k = 1; k <= terms; k++) begin
      n = (mode == WAVE_SQUARE || mode == WAVE_TRIANGLE) ? 2 * k - 1 : k;
      d = (mode == WAVE_TRIANGLE) ? n * n : n;
      w = ((64'd1 << 24) + d / 2) / d;
      hp = n * phase_acc;
      idx = (64'(hp) * SINE_TABLE_DEPTH) >> 32;
      term = longint'(sine_lut[idx]) * w;
      if ((mode == WAVE_SAW_UP || mode == WAVE_TRIANGLE) && (k % 2) == 0) begin
        sum -= term;
      end else begin
        sum += term;
      end
    end
    case (mode)
      WAVE_SINE: gain = GAIN_UNITY;
      WAVE_SQUARE: gain = GAIN_SQUARE;
      WAVE_TRIANGLE: gain = GAIN_TRIANGLE;
      default: gain = GAIN_SAW;
    endcase
    y = round_away(sum, 24);
    y = round_away(y * gain, 30);
    y = round_away(y * longint'(amp_reg), 40 - SB);
    r.clipped = 1'b0;
    if (y > SAMPLE_HI) begin
      y = SAMPLE_HI;
      r.clipped = 1'b1;
    end else if (y < SAMPLE_LO) begin
      y = SAMPLE_LO;
      r.clipped = 1'b1;
    end
    r.sample = y[SB-1:0];
    phase_acc += step_reg;
    return r;
  endfunction

  task automatic report_err(input string msg);
    $display("ERROR cycle %0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  task automatic add_write(input cfg_reg_t idx, input logic [31:0] data);
    bringup_row_t row;
    row = '{ROW_WRITE, idx, data, 1'b0, 1'b0, '0};
    bringup_rows = {bringup_rows, row};
  endtask

  task automatic add_item(input logic r, input bit typed, input logic signed [SB-1:0] s);
    bringup_row_t row;
    row = '{ROW_ITEM, REG_WAVEFORM, 32'd0, r, typed, s};
    bringup_rows = {bringup_rows, row};
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_WAVEFORM: wave_reg = data[2:0];
      REG_AMPLITUDE: amp_reg = data[15:0];
      REG_PHASE_STEP: step_reg = data;
      REG_HARMONIC_COUNT: hcount_reg = data[6:0];
      default: ;
    endcase
  endtask

  task automatic send_item(input logic r, input bit typed, input logic signed [SB-1:0] s);
    synth_out_t e;
    in_valid <= 1'b1;
    in_restart <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    e = synth_next(r);
    if (typed) begin
      e.sample = s;
      e.clipped = 1'b0;
    end
    pending_samples = {pending_samples, e};
    samples_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (samples_taken < samples_sent) @(posedge clk);
  endtask

  // result side: check, then pick next ready
  always @(posedge clk) begin
    synth_out_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_samples.size() == 0) begin
          report_err($sformatf("unexpected item sample %0d", out_sample));
        end else begin
          e = pending_samples.pop_front();
          if (out_sample !== e.sample) begin
            report_err($sformatf("sample got %0d want %0d", out_sample, e.sample));
          end
          if (out_clipped !== e.clipped) begin
            report_err($sformatf("clipped got %b want %b", out_clipped, e.clipped));
          end
        end
        samples_taken <= samples_taken + 1;
      end
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_cycle % HOLD_PERIOD == HOLD_PERIOD / 2) begin
        hold_left = HOLD_LEN;
        out_ready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          rx_pat = rx_pattern_t'($urandom_range(0, 3));
          pattern_left = $urandom_range(20, 300);
        end
        pattern_left--;
        case (rx_pat)
          RX_OPEN: out_ready <= 1'b1;
          RX_COIN: out_ready <= 1'($urandom_range(0, 1));
          RX_EVERY4: out_ready <= (rx_cycle % 4 == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("bandlimited_wave_synth verification failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] ph;
    longint unsigned u;
    longint unsigned mag;
    logic [31:0] junk;
    logic [15:0] amp16;
    logic [31:0] step32;
    logic [6:0] hc7;
    bit cfg_open;
    int n_items;
    int gap;
    int burst_left;
    int rand_sent;

    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      ph = 32'((64'd1 << 32) * i / SINE_TABLE_DEPTH);
      u = 64'(ph[29:0]);
      if (ph[30]) begin
        u = (64'd1 << 30) - u;
      end
      mag = poly_mag(u);
      sine_lut[i] = ph[31] ? -int'(mag) : int'(mag);
    end

    // after reset: zero amplitude
    add_item(1'b0, 1'b1, 24'sd0);
    // full-scale sine at quarter-cycle steps, then wrap to zero
    add_write(REG_AMPLITUDE, 32'd65535);
    add_write(REG_PHASE_STEP, 32'h4000_0000);
    add_item(1'b1, 1'b1, 24'sd0);
    add_item(1'b0, 1'b1, 24'sd4194240);
    add_item(1'b0, 1'b1, 24'sd0);
    add_item(1'b0, 1'b1, -24'sd4194240);
    add_item(1'b0, 1'b1, 24'sd0);
    add_write(REG_WAVEFORM, 32'(WAVE_SAW_DOWN));
    add_write(REG_HARMONIC_COUNT, 32'd64);
    add_write(REG_PHASE_STEP, 32'h0123_4567);
    add_item(1'b1, 1'b0, '0);
    add_item(1'b0, 1'b0, '0);
    add_write(REG_WAVEFORM, 32'(WAVE_SQUARE));
    add_item(1'b0, 1'b0, '0);
    add_write(REG_WAVEFORM, 32'(WAVE_SAW_UP));
    add_item(1'b1, 1'b0, '0);
    add_item(1'b0, 1'b0, '0);
    add_write(REG_WAVEFORM, 32'(WAVE_TRIANGLE));
    add_item(1'b0, 1'b0, '0);
    add_item(1'b0, 1'b0, '0);
    // count of zero and a count above the maximum
    add_write(REG_HARMONIC_COUNT, 32'd0);
    add_item(1'b0, 1'b0, '0);
    add_write(REG_HARMONIC_COUNT, 32'd127);
    add_item(1'b0, 1'b0, '0);
    // unused waveform codes fall back to sine
    add_write(REG_WAVEFORM, 32'(WAVE_UNUSED_7));
    add_item(1'b0, 1'b0, '0);
    add_write(REG_WAVEFORM, 32'(WAVE_UNUSED_5));
    add_item(1'b0, 1'b0, '0);
    add_write(REG_WAVEFORM, 32'(WAVE_SQUARE));
    add_write(REG_HARMONIC_COUNT, 32'd64);
    add_write(REG_AMPLITUDE, 32'd1);
    add_write(REG_PHASE_STEP, 32'hFFFF_FFFF);
    add_item(1'b0, 1'b0, '0);
    add_item(1'b0, 1'b0, '0);
    add_write(REG_PHASE_STEP, 32'h8000_0000);
    add_write(REG_AMPLITUDE, 32'd0);
    add_item(1'b0, 1'b1, 24'sd0);
    add_write(REG_AMPLITUDE, 32'd65535);
    add_item(1'b0, 1'b0, '0);
    add_item(1'b0, 1'b0, '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    cfg_open = 1'b0;
    foreach (bringup_rows[i]) begin
      if (bringup_rows[i].kind == ROW_WRITE) begin
        if (!cfg_open) begin
          drain();
          cfg_open = 1'b1;
        end
        write_reg(bringup_rows[i].idx, bringup_rows[i].data);
      end else begin
        if (cfg_open) begin
          cfg_valid <= 1'b0;
          cfg_open = 1'b0;
        end
        send_item(bringup_rows[i].restart, bringup_rows[i].typed, bringup_rows[i].sample);
      end
    end

    rand_sent = 0;
    while (rand_sent < RAND_ITEMS) begin
      drain();
      junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
      if ($urandom_range(0, 15) < 14) begin
        write_reg(REG_WAVEFORM, {junk[31:3], 3'($urandom_range(0, 4))});
      end else begin
        write_reg(REG_WAVEFORM, {junk[31:3], 3'($urandom_range(5, 7))});
      end
      case ($urandom_range(0, 7))
        0: amp16 = 16'd0;
        1: amp16 = 16'hFFFF;
        2: amp16 = 16'd1;
        default: amp16 = 16'($urandom);
      endcase
      junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
      write_reg(REG_AMPLITUDE, {junk[31:16], amp16});
      case ($urandom_range(0, 7))
        0: step32 = 32'd0;
        1: step32 = 32'hFFFF_FFFF;
        2: step32 = 32'h8000_0000;
        3, 4: step32 = $urandom_range(32'h0040_0000, 0);
        default: step32 = $urandom;
      endcase
      write_reg(REG_PHASE_STEP, step32);
      case ($urandom_range(0, 9))
        0: hc7 = 7'd0;
        1: hc7 = 7'($urandom_range(65, 127));
        2: hc7 = 7'd1;
        3: hc7 = 7'd64;
        default: hc7 = 7'($urandom_range(1, 64));
      endcase
      junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
      write_reg(REG_HARMONIC_COUNT, {junk[31:7], hc7});
      cfg_valid <= 1'b0;

      n_items = $urandom_range(10, 80);
      burst_left = 0;
      for (int j = 0; j < n_items; j++) begin
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        send_item((j == 0 && $urandom_range(0, 1) == 1) || $urandom_range(0, 19) == 0,
                  1'b0, '0);
        rand_sent++;
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("bandlimited_wave_synth verification clean");
    end else begin
      $display("bandlimited_wave_synth verification failed");
    end
    $finish;
  end

endmodule
